/* rtl/rlm_pkg.sv */
// Shared constants, state codes and control structs of the RMS level meter.
// Used by every module of the block; depends on nothing.
package rlm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_BLOCK   = 4096;

	localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
	localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W   = 2 * SAMPLE_BITS - 2 + CNT_W;
	localparam int QUO_W   = 2 * SAMPLE_BITS - 1;
	localparam int ROOT_W  = SAMPLE_BITS;
	localparam int LEVEL_W = 16;
	localparam int DECAY_W = 24;
	localparam int CHAN_W  = 2;
	localparam int PROD_W  = LEVEL_W + DECAY_W;
	localparam int STEP_W  = $clog2(SUM_W);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd1;

	localparam logic [DECAY_W-1:0] DECAY_RESET = 24'd16773997;
	localparam logic [CHAN_W-1:0]  CHAN_NONE   = 2'd0;
	localparam logic [CHAN_W-1:0]  CHAN_MONO   = 2'd1;
	localparam logic [CHAN_W-1:0]  CHAN_RESET  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_DIV_LD,
		ST_DIV,
		ST_SQRT_LD,
		ST_SQRT,
		ST_MUL,
		ST_UPD,
		ST_OUT
	} rlm_state_t;

	typedef struct packed {
		logic cap;
		logic sq;
		logic acc;
		logic div_ld;
		logic div_step;
		logic sqrt_ld;
		logic sqrt_step;
		logic mul;
		logic upd;
		logic out_ld;
	} rlm_cmd_t;

	typedef struct packed {
		logic chan_none;
		logic last;
	} rlm_stat_t;

endpackage

/* rtl/rlm_lane.sv */
// One channel's block-end arithmetic: a bit-serial restoring divider for
// sum / count, then a digit-by-digit integer square root. Uses rlm_pkg.
module rlm_lane (
	input  logic                          clk,
	input  rlm_pkg::rlm_cmd_t             cmd,
	input  logic [rlm_pkg::SUM_W-1:0]     sum,
	input  logic [rlm_pkg::CNT_W-1:0]     count,
	output logic [rlm_pkg::ROOT_W-1:0]    root
);
	import rlm_pkg::*;

	localparam int OP_W  = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int SH_W  = ROOT_W + 4;

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  drem_q;
	logic [CNT_W:0]    drem_sh;
	logic              dbit;

	logic [OP_W-1:0]   op_q;
	logic [REM_W-1:0]  srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SH_W-1:0]   srem_sh;
	logic [SH_W-1:0]   trial;
	logic              sbit;

	// Divider step: shift in the next dividend bit and subtract when it fits.
	always_comb begin
		drem_sh = {drem_q, dvd_q[SUM_W-1]};
		dbit    = (drem_sh >= {1'b0, count});
	end

	// Root step: bring down two operand bits and try 4*root + 1.
	always_comb begin
		srem_sh = {srem_q, op_q[OP_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		sbit    = (srem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_ld) begin
			dvd_q  <= sum;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], dbit};
			if (dbit) begin
				drem_q <= CNT_W'(drem_sh - {1'b0, count});
			end else begin
				drem_q <= drem_sh[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_ld) begin
			op_q   <= {1'b0, dvd_q[QUO_W-1:0]};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			op_q <= {op_q[OP_W-3:0], 2'b00};
			if (sbit) begin
				srem_q <= REM_W'(srem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;

endmodule

/* rtl/rlm_dp.sv */
// Datapath of the level meter: configuration registers, square and sum
// accumulation, two lanes, the release multiply and the result register.
// Uses rlm_pkg and rlm_lane.
module rlm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlm_pkg::rlm_cmd_t                   cmd,
	output rlm_pkg::rlm_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [rlm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rlm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] left_sample,
	input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] right_sample,
	input  logic                                last_in_block,
	output logic [rlm_pkg::LEVEL_W-1:0]         left_level,
	output logic [rlm_pkg::LEVEL_W-1:0]         right_level,
	output logic                                overflow
);
	import rlm_pkg::*;

	logic [DECAY_W-1:0] decay_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               stereo;

	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic                          last_q;
	logic [SQ_W-1:0]               sq_l_s1, sq_r_s1;
	logic signed [2*SAMPLE_BITS-1:0] sq_l_full, sq_r_full;

	logic [SUM_W-1:0]   sum_l_q, sum_r_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;

	logic [ROOT_W-1:0]  rms_l, rms_r;
	logic [PROD_W-1:0]  prod_l_q, prod_r_q;
	logic [LEVEL_W-1:0] held_l_q, held_r_q;
	logic [LEVEL_W-1:0] new_l, new_r;

	logic [LEVEL_W-1:0] out_l_q, out_r_q;
	logic               out_ovf_q;

	// Channel code 3 is treated as stereo.
	assign stereo = (chan_q != CHAN_NONE) && (chan_q != CHAN_MONO);

	assign stat.chan_none = (chan_q == CHAN_NONE);
	assign stat.last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
			chan_q  <= CHAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY:    decay_q <= cfg_data[DECAY_W-1:0];
				REG_CHANNELS: chan_q  <= cfg_data[CHAN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			left_q  <= left_sample;
			right_q <= right_sample;
			last_q  <= last_in_block;
		end
	end

	assign sq_l_full = left_q * left_q;
	assign sq_r_full = right_q * right_q;

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			sq_l_s1 <= sq_l_full[SQ_W-1:0];
			sq_r_s1 <= sq_r_full[SQ_W-1:0];
		end
	end

	// Sums and count saturate at the block bound; further frames only flag it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.out_ld) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.acc) begin
			if (cnt_q < CNT_W'(MAX_BLOCK)) begin
				sum_l_q <= sum_l_q + SUM_W'(sq_l_s1);
				if (stereo) begin
					sum_r_q <= sum_r_q + SUM_W'(sq_r_s1);
				end
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	rlm_lane u_lane_l (
		.clk   (clk),
		.cmd   (cmd),
		.sum   (sum_l_q),
		.count (cnt_q),
		.root  (rms_l)
	);

	rlm_lane u_lane_r (
		.clk   (clk),
		.cmd   (cmd),
		.sum   (sum_r_q),
		.count (cnt_q),
		.root  (rms_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_l_q <= held_l_q * decay_q;
			prod_r_q <= held_r_q * decay_q;
		end
	end

	always_comb begin
		new_l = (rms_l > held_l_q) ? rms_l : prod_l_q[PROD_W-1 -: LEVEL_W];
		new_r = (rms_r > held_r_q) ? rms_r : prod_r_q[PROD_W-1 -: LEVEL_W];
	end

	// In mono the left outcome is copied to both levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q <= '0;
			held_r_q <= '0;
		end else if (cmd.upd) begin
			held_l_q <= new_l;
			held_r_q <= stereo ? new_r : new_l;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_l_q   <= held_l_q;
			out_r_q   <= held_r_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign left_level  = out_l_q;
	assign right_level = out_r_q;
	assign overflow    = out_ovf_q;

endmodule

/* rtl/rlm_ctrl.sv */
// Controller of the level meter: sequences accumulation, division, square
// root and release, and owns the result valid flag. Uses rlm_pkg.
module rlm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rlm_pkg::rlm_stat_t stat,
	output rlm_pkg::rlm_cmd_t  cmd
);
	import rlm_pkg::*;

	rlm_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !stat.chan_none) begin
					cmd.cap = 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last ? ST_DIV_LD : ST_IDLE;
			end
			ST_DIV_LD: begin
				cmd.div_ld = 1'b1;
				step_d     = '0;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_SQRT_LD;
				end
			end
			ST_SQRT_LD: begin
				cmd.sqrt_ld = 1'b1;
				step_d      = '0;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_d        = step_q + 1'b1;
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/rms_level_meter_with_decay_top.sv */
// Top level of the RMS level meter with exponential release.
// Joins rlm_ctrl and rlm_dp; uses rlm_pkg.
//
//   Channel   Signals                                          Direction
//   -------   ----------------------------------------------   ---------
//   in        in_valid, in_ready, left_sample, right_sample,   to block
//             last_in_block
//   out       out_valid, out_ready, left_level, right_level,   from block
//             overflow
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data        to block
//
// A frame that does not end its block passes through capture, square and add.
// A frame that ends its block then passes through the divider load, the
// 43-step bit-serial divider, the root load, the 16-step square root, the
// release multiply, the level update and the result load.
// Reset clears the sums, the frame count, the held levels and the overflow
// flag at once and sets the configuration registers to their defaults.
// A stalled result only holds the block when the next block end wants the
// result register; frames in between keep being taken.
module rms_level_meter_with_decay_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] left_sample,
	input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] right_sample,
	input  logic                                   last_in_block,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rlm_pkg::LEVEL_W-1:0]            left_level,
	output logic [rlm_pkg::LEVEL_W-1:0]            right_level,
	output logic                                   overflow,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rlm_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rlm_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import rlm_pkg::*;

	rlm_cmd_t  cmd;
	rlm_stat_t stat;

	// Configuration is to be written only while the meter is idle; the user must
	// keep to this, as the block does not enforce it. cfg_ready is tied high, so a write is always taken.
	assign cfg_ready = 1'b1;

	rlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rlm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.last_in_block (last_in_block),
		.left_level    (left_level),
		.right_level   (right_level),
		.overflow      (overflow)
	);

endmodule

/* rtl/rlm_checker.sv */
// Port-level checks of the level meter and the bind that attaches them.
// Uses rlm_pkg; binds to rms_level_meter_with_decay_top.
module rlm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        last_in_block,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rlm_pkg::LEVEL_W-1:0] left_level,
	input logic [rlm_pkg::LEVEL_W-1:0] right_level
);
	import rlm_pkg::*;

	// A waiting result word holds its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_level)
			&& $stable(right_level))
		else $error("result word changed while stalled");

	// Levels never exceed full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_level <= LEVEL_W'(32768))
			&& (right_level <= LEVEL_W'(32768)))
		else $error("level above full scale");

	// A frame that does not end its block produces no result word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_in_block && !out_valid |=> !out_valid)
		else $error("result word without a block end");

endmodule

bind rms_level_meter_with_decay_top rlm_checker u_rlm_checker (.*);
